// ===== rtl/core/sfh_pkg.sv =====
// Shared types, frame constants and the seven-segment digit decode.
// No dependencies; imported by every module of the frame height parser.

package sfh_pkg;

    localparam int HEIGHT_W = 14;
    localparam int HIST_DEPTH = 5;

    typedef logic [7:0] t_byte;
    typedef logic [3:0] t_digit;
    typedef logic [HEIGHT_W-1:0] t_height;

    // Frame markers and the accepted frame type
    localparam t_byte START_BYTE = 8'h9B;
    localparam t_byte END_BYTE = 8'h9D;
    localparam t_byte HEIGHT_TYPE = 8'h12;
    localparam t_byte LEN_SHORT = 8'd7;
    localparam t_byte LEN_LONG = 8'd10;

    // Decimal point sits in bit 7 of a digit byte
    localparam int DP_BIT = 7;

    // Dash pattern decodes to this value
    localparam t_digit DASH_VAL = 4'd10;

    localparam t_height MAX_HEIGHT = 14'd11000;

    // Seven-segment patterns of the digits 0 to 9, then the dash
    localparam t_byte SEG_TABLE [0:10] = '{
        8'h7E, 8'h06, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70, 8'h7F, 8'h7B, 8'h01
    };

    // One reported height word
    typedef struct packed {
        logic    valid;
        t_height value;
    } t_emit;

    // Decode one segment byte; the decimal point is ignored
    function automatic t_digit seg_decode(input t_byte raw);
        t_digit d;
        case (raw[6:0])
            7'h7E:   d = 4'd0;
            7'h06:   d = 4'd1;
            7'h6D:   d = 4'd2;
            7'h79:   d = 4'd3;
            7'h33:   d = 4'd4;
            7'h5B:   d = 4'd5;
            7'h5F:   d = 4'd6;
            7'h70:   d = 4'd7;
            7'h7F:   d = 4'd8;
            7'h7B:   d = 4'd9;
            7'h01:   d = DASH_VAL;
            default: d = 4'd0;
        endcase
        return d;
    endfunction

endpackage

// ===== rtl/core/segment_frame_height_parser_top.sv =====
// Top level of the segment frame height parser: input and result registers.
// Depends on sfh_pkg and sfh_frame_core.
//
//  channel  | valid   | ready   | payload
//  ---------+---------+---------+-----------------
//  rx word  | i_valid | o_ready | i_rx_byte
//  height   | o_valid | i_ready | o_height_tenths
//
// One byte per cycle sustained while the result is not stalled; an accepted
// byte goes from the input register through the frame state step into the
// result register. Reset (i_rst_n low, synchronous) clears the history,
// frame flags, heights and both register valids. A stalled result holds the
// frame step; the input register keeps its byte and o_ready stays low.

module segment_frame_height_parser_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  sfh_pkg::t_byte   i_rx_byte,
    output logic             o_valid,
    input  logic             i_ready,
    output sfh_pkg::t_height o_height_tenths
);
    import sfh_pkg::*;

    logic    r_in_valid;
    t_byte   r_in_byte;
    logic    r_out_valid;
    t_height r_out_height;
    logic    w_step;
    t_emit   w_emit;

    // Advance the held byte when the result slot is free or being drained
    assign w_step  = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || w_step;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    sfh_frame_core u_core (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_step (w_step),
        .i_byte (r_in_byte),
        .o_emit (w_emit)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            r_out_valid <= w_emit.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit.valid) begin
            r_out_height <= w_emit.value;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_height_tenths = r_out_height;

endmodule

// ===== rtl/core/sfh_height_calc.sv =====
// Combinational height arithmetic: three segment bytes to a height in tenths.
// Depends on sfh_pkg for the digit decode and width types.

module sfh_height_calc (
    input  sfh_pkg::t_byte   i_first,
    input  sfh_pkg::t_byte   i_mid,
    input  sfh_pkg::t_byte   i_last,
    output sfh_pkg::t_height o_height,
    output logic             o_mid_dash
);
    import sfh_pkg::*;

    t_digit     w_first;
    t_digit     w_mid;
    t_digit     w_last;
    logic [10:0] w_raw;

    // Decode each digit
    assign w_first = seg_decode(i_first);
    assign w_mid   = seg_decode(i_mid);
    assign w_last  = seg_decode(i_last);

    assign o_mid_dash = (w_mid == DASH_VAL);

    // Combine digits: first*100 + mid*10 + last, at most 1110
    assign w_raw = ({7'd0, w_first} << 6) + ({7'd0, w_first} << 5)
                 + ({7'd0, w_first} << 2)
                 + ({7'd0, w_mid} << 3) + ({7'd0, w_mid} << 1)
                 + {7'd0, w_last};

    // Scale to tenths unless the middle digit carries the decimal point
    always_comb begin
        if (i_mid[DP_BIT]) begin
            o_height = {3'd0, w_raw};
        end else begin
            o_height = ({3'd0, w_raw} << 3) + ({3'd0, w_raw} << 1);
        end
    end

endmodule

// ===== rtl/core/sfh_frame_core.sv =====
// Frame tracking state: byte history, length/type/valid flags and heights.
// Depends on sfh_pkg and sfh_height_calc; one byte is consumed per step.

module sfh_frame_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_step,
    input  sfh_pkg::t_byte i_byte,
    output sfh_pkg::t_emit o_emit
);
    import sfh_pkg::*;

    t_byte   r_hist [HIST_DEPTH];
    t_byte   n_hist [HIST_DEPTH];
    t_byte   r_len;
    t_byte   n_len;
    t_byte   r_type;
    t_byte   n_type;
    logic    r_valid;
    logic    n_valid;
    t_height r_cur;
    t_height n_cur;
    t_height r_last;
    t_height n_last;

    t_height w_height;
    logic    w_mid_dash;

    // Height from first digit, middle digit and the incoming last digit
    sfh_height_calc u_calc (
        .i_first   (r_hist[1]),
        .i_mid     (r_hist[0]),
        .i_last    (i_byte),
        .o_height  (w_height),
        .o_mid_dash(w_mid_dash)
    );

    // Next state for one word
    always_comb begin
        n_len   = r_len;
        n_type  = r_type;
        n_valid = r_valid;
        n_cur   = r_cur;
        n_last  = r_last;
        o_emit  = '0;

        // A start byte clears the frame before its place is judged
        if (i_byte == START_BYTE) begin
            n_len   = '0;
            n_valid = 1'b0;
        end

        // Place in frame from the history before the shift
        if (r_hist[0] == START_BYTE) begin
            n_len = i_byte;
        end else if (r_hist[1] == START_BYTE) begin
            n_type = i_byte;
        end else if (r_hist[2] == START_BYTE) begin
            if (r_type == HEIGHT_TYPE && (n_len == LEN_SHORT || n_len == LEN_LONG)
                    && seg_decode(i_byte) != 4'd0) begin
                n_valid = 1'b1;
            end
        end else if (r_hist[3] == START_BYTE) begin
            // middle digit: nothing yet
        end else if (r_hist[4] == START_BYTE && n_valid) begin
            if (!w_mid_dash) begin
                n_cur = w_height;
            end
        end

        // Shift history
        n_hist[0] = i_byte;
        for (int i = 1; i < HIST_DEPTH; i++) begin
            n_hist[i] = r_hist[i-1];
        end

        // Report a changed, nonzero height on the end byte
        if (i_step && i_byte == END_BYTE && n_cur != '0 && n_cur != r_last) begin
            o_emit.valid = 1'b1;
            o_emit.value = n_cur;
            n_last       = n_cur;
        end
    end

    // Hold or advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HIST_DEPTH; i++) begin
                r_hist[i] <= '0;
            end
            r_len   <= '0;
            r_type  <= '0;
            r_valid <= 1'b0;
            r_cur   <= '0;
            r_last  <= '0;
        end else if (i_step) begin
            for (int i = 0; i < HIST_DEPTH; i++) begin
                r_hist[i] <= n_hist[i];
            end
            r_len   <= n_len;
            r_type  <= n_type;
            r_valid <= n_valid;
            r_cur   <= n_cur;
            r_last  <= n_last;
        end
    end

    a_emit_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit.valid |-> o_emit.value != '0)
        else $error("emitted height is zero");

    a_emit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit.valid |-> o_emit.value <= MAX_HEIGHT)
        else $error("emitted height out of range");

    a_emit_changed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit.valid |-> o_emit.value != r_last)
        else $error("emitted height repeats the last one");

    a_last_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit.valid |=> r_last == $past(o_emit.value))
        else $error("last emitted height not updated");

endmodule
